>>> design/bkb_pkg.sv
// Shared types and constants for the bounded key blocklist.
package bkb_pkg;

	// Table size and derived widths.
	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int TOTAL_W       = 10;

	// Key layout: high, middle and low parts, high part in the upper bits.
	localparam int KEY_HIGH_W   = 64;
	localparam int KEY_MIDDLE_W = 64;
	localparam int KEY_LOW_W    = 32;
	localparam int KEY_W        = KEY_HIGH_W + KEY_MIDDLE_W + KEY_LOW_W;

	// Stream widths.
	localparam int OPCODE_W  = 2;
	localparam int STATUS_W  = 2;
	localparam int IN_DATA_W = 168;
	localparam int OUT_DATA_W = 16;

	// Command queue between the front and the back.
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;
	localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

	// Opcode values on the input stream.
	localparam logic [OPCODE_W-1:0] OPC_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OPC_REMOVE = 2'd1;
	localparam logic [OPCODE_W-1:0] OPC_QUERY  = 2'd2;

	// Decoded command kind.
	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_QUERY,
		OP_NONE
	} op_kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_MOVE_RD,
		S_MOVE_WR,
		S_RESP
	} bkb_state_t;

	// One classified command as it waits in the queue.
	typedef struct packed {
		op_kind_t         op;
		logic [KEY_W-1:0] key;
	} cmd_t;

endpackage

>>> design/bkb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bkb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/bkb_front.sv
// Front end: accepts input items, decodes the opcode and queues commands.
module bkb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bkb_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              q_valid,
	output bkb_pkg::cmd_t                     q_cmd,
	input  logic                              q_take
);

	logic [bkb_pkg::OPCODE_W-1:0]     opcode;
	logic [bkb_pkg::KEY_HIGH_W-1:0]   key_high;
	logic [bkb_pkg::KEY_MIDDLE_W-1:0] key_middle;
	logic [bkb_pkg::KEY_LOW_W-1:0]    key_low;
	bkb_pkg::cmd_t                    cmd_in;
	logic                             push;
	logic                             pop;

	bkb_pkg::cmd_t                    fifo_q [bkb_pkg::Q_DEPTH];
	logic [bkb_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [bkb_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [bkb_pkg::Q_FILL_W-1:0]     fill_q;

	// Unpack the input item.
	assign opcode     = s_tdata[1:0];
	assign key_high   = s_tdata[65:2];
	assign key_middle = s_tdata[129:66];
	assign key_low    = s_tdata[161:130];

	// Classify the opcode; the unused code becomes a no-op that reports a miss.
	always_comb begin
		cmd_in.key = {key_high, key_middle, key_low};
		case (opcode)
			bkb_pkg::OPC_INSERT: cmd_in.op = bkb_pkg::OP_INSERT;
			bkb_pkg::OPC_REMOVE: cmd_in.op = bkb_pkg::OP_REMOVE;
			bkb_pkg::OPC_QUERY:  cmd_in.op = bkb_pkg::OP_QUERY;
			default:             cmd_in.op = bkb_pkg::OP_NONE;
		endcase
	end

	// Queue handshakes.
	assign s_tready = (fill_q != bkb_pkg::Q_FILL_W'(bkb_pkg::Q_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_take && q_valid;
	assign q_cmd    = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> design/bkb_back.sv
// Back end: scans the key table, applies the command and holds the result item.
module bkb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  bkb_pkg::cmd_t                   q_cmd,
	output logic                            q_take,
	output logic                            rd_en,
	output logic [bkb_pkg::IDX_W-1:0]       rd_addr,
	input  logic [bkb_pkg::KEY_W-1:0]       rd_data,
	output logic                            wr_en,
	output logic [bkb_pkg::IDX_W-1:0]       wr_addr,
	output logic [bkb_pkg::KEY_W-1:0]       wr_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bkb_pkg::STATUS_W-1:0]    out_status,
	output logic [bkb_pkg::TOTAL_W-1:0]     out_total
);

	bkb_pkg::bkb_state_t            state_q;
	bkb_pkg::bkb_state_t            state_next;
	bkb_pkg::cmd_t                  cmd_q;
	logic [bkb_pkg::CNT_W-1:0]      count_q;
	logic [bkb_pkg::CNT_W-1:0]      scan_idx_q;
	logic                           cmp_vld_q;
	logic [bkb_pkg::IDX_W-1:0]      cmp_idx_q;
	logic                           found_q;
	logic [bkb_pkg::IDX_W-1:0]      slot_q;
	bkb_pkg::status_t               status_q;
	logic                           out_vld_q;
	logic [bkb_pkg::STATUS_W-1:0]   out_status_q;
	logic [bkb_pkg::TOTAL_W-1:0]    out_total_q;

	logic                           issue;
	logic                           match;
	logic                           out_free;
	logic                           has_room;
	logic [bkb_pkg::CNT_W-1:0]      last;

	// Scan helpers.
	assign issue    = (state_q == bkb_pkg::S_SCAN) && (scan_idx_q < count_q);
	assign match    = cmp_vld_q && (rd_data == cmd_q.key);
	assign out_free = !out_vld_q || out_ready;
	assign has_room = (count_q < bkb_pkg::CNT_W'(bkb_pkg::TABLE_ENTRIES));
	assign last     = count_q - 1'b1;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			bkb_pkg::S_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == bkb_pkg::OP_NONE) begin
						state_next = bkb_pkg::S_RESP;
					end else begin
						state_next = bkb_pkg::S_SCAN;
					end
				end
			end
			bkb_pkg::S_SCAN: begin
				if (match || (!issue && !cmp_vld_q)) begin
					state_next = bkb_pkg::S_EXEC;
				end
			end
			bkb_pkg::S_EXEC: begin
				if ((cmd_q.op == bkb_pkg::OP_REMOVE) && found_q) begin
					state_next = bkb_pkg::S_MOVE_RD;
				end else begin
					state_next = bkb_pkg::S_RESP;
				end
			end
			bkb_pkg::S_MOVE_RD: state_next = bkb_pkg::S_MOVE_WR;
			bkb_pkg::S_MOVE_WR: state_next = bkb_pkg::S_RESP;
			bkb_pkg::S_RESP: begin
				if (out_free) begin
					state_next = bkb_pkg::S_IDLE;
				end
			end
			default: state_next = bkb_pkg::S_IDLE;
		endcase
	end

	// Memory and queue controls.
	always_comb begin
		q_take  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = scan_idx_q[bkb_pkg::IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[bkb_pkg::IDX_W-1:0];
		wr_data = cmd_q.key;
		case (state_q)
			bkb_pkg::S_IDLE: q_take = q_valid;
			bkb_pkg::S_SCAN: rd_en = issue;
			bkb_pkg::S_EXEC: begin
				wr_en = (cmd_q.op == bkb_pkg::OP_INSERT) && !found_q && has_room;
			end
			bkb_pkg::S_MOVE_RD: begin
				rd_en   = 1'b1;
				rd_addr = last[bkb_pkg::IDX_W-1:0];
			end
			bkb_pkg::S_MOVE_WR: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = rd_data;
			end
			default: ;
		endcase
	end

	// Command registers and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (state_q == bkb_pkg::S_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		cmp_idx_q <= scan_idx_q[bkb_pkg::IDX_W-1:0];
		if (match) begin
			slot_q <= cmp_idx_q;
		end
		if (state_q == bkb_pkg::S_RESP && out_free) begin
			out_status_q <= status_q;
			out_total_q  <= bkb_pkg::TOTAL_W'(count_q);
		end
	end

	// Control state: sequencer, count, scan progress, status and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bkb_pkg::S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_q  <= 1'b0;
			found_q    <= 1'b0;
			status_q   <= bkb_pkg::STAT_MISS;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_next;
			cmp_vld_q <= issue && !match;
			if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (match) begin
				found_q <= 1'b1;
			end
			case (state_q)
				bkb_pkg::S_IDLE: begin
					if (q_valid) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						status_q   <= bkb_pkg::STAT_MISS;
					end
				end
				bkb_pkg::S_EXEC: begin
					case (cmd_q.op)
						bkb_pkg::OP_INSERT: begin
							if (found_q) begin
								status_q <= bkb_pkg::STAT_DONE;
							end else if (has_room) begin
								count_q  <= count_q + 1'b1;
								status_q <= bkb_pkg::STAT_DONE;
							end else begin
								status_q <= bkb_pkg::STAT_FULL;
							end
						end
						bkb_pkg::OP_REMOVE, bkb_pkg::OP_QUERY: begin
							if (found_q) begin
								status_q <= bkb_pkg::STAT_DONE;
							end else begin
								status_q <= bkb_pkg::STAT_MISS;
							end
						end
						default: status_q <= bkb_pkg::STAT_MISS;
					endcase
				end
				bkb_pkg::S_MOVE_WR: count_q <= last;
				default: ;
			endcase
			// Output register: load on a free slot, drop once taken.
			if (state_q == bkb_pkg::S_RESP && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_status = out_status_q;
	assign out_total  = out_total_q;

endmodule

>>> design/bounded_key_blocklist.sv
// Bounded 160-bit key blocklist: a compact key table with a live count.
// Each command scans the table linearly, stopping at a match; a successful remove then
// moves the last entry into the freed slot, and the unused opcode skips the scan.
// A new item leaves the queue only once the previous result is in the result register,
// so the rate is set by the linear scan through the single read port of the key RAM.
// Reset: arst_n clears the count, queue and result valid; result data and key RAM are not cleared.
module bounded_key_blocklist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: opcode[1:0], key_high[65:2], key_middle[129:66], key_low[161:130].
	input  logic [bkb_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: status[1:0], entry_total[11:2].
	output logic [bkb_pkg::OUT_DATA_W-1:0]    m_tdata
);

	logic                              q_valid;
	bkb_pkg::cmd_t                     q_cmd;
	logic                              q_take;
	logic                              rd_en;
	logic [bkb_pkg::IDX_W-1:0]         rd_addr;
	logic [bkb_pkg::KEY_W-1:0]         rd_data;
	logic                              wr_en;
	logic [bkb_pkg::IDX_W-1:0]         wr_addr;
	logic [bkb_pkg::KEY_W-1:0]         wr_data;
	logic [bkb_pkg::STATUS_W-1:0]      out_status;
	logic [bkb_pkg::TOTAL_W-1:0]       out_total;

	// Input side: decode and queue.
	bkb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_take   (q_take)
	);

	// Execution side: table scan and update.
	bkb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_take     (q_take),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_total  (out_total)
	);

	// Key table.
	bkb_ram #(
		.WIDTH (bkb_pkg::KEY_W),
		.DEPTH (bkb_pkg::TABLE_ENTRIES)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Pack the result item.
	assign m_tdata = {4'b0, out_total, out_status};

endmodule
